FILE: rtl/dnsf_pkg.sv
// dnsf_pkg: shared types, constants and field positions of the dns resolver packet filter
// used by the frame parser, the top level and the checker
// no dependencies
package dnsf_pkg;

   // saturation limit of the per-frame byte count
   localparam int MAX_FRAME_BYTES = 16383;
   localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);

   localparam int ETH_LEN         = 14;
   localparam int IP_HDR_MIN      = 20;
   localparam int WORD_BYTES      = 4;
   localparam int MIN_IHL         = 5;
   localparam int MAX_IHL         = 15;
   localparam int L4_PORT_BYTES   = 4;
   localparam int DPORT_OFS       = 2;
   localparam int L4_W            = $clog2(ETH_LEN + WORD_BYTES * MAX_IHL + L4_PORT_BYTES + 1);

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;
   localparam logic [15:0] RESOLVER_PORT  = 16'd53;

   typedef logic [POS_W-1:0] pos_type;
   typedef logic [L4_W-1:0]  l4_type;

   // byte offsets within the ethernet frame
   localparam pos_type POS_ETYPE_HI    = POS_W'(12);
   localparam pos_type POS_ETYPE_LO    = POS_W'(13);
   localparam pos_type POS_IHL         = POS_W'(14);
   localparam pos_type POS_FRAG_HI     = POS_W'(20);
   localparam pos_type POS_FRAG_LO     = POS_W'(21);
   localparam pos_type POS_PROTO       = POS_W'(23);
   localparam pos_type POS_DADDR_FIRST = POS_W'(30);
   localparam pos_type POS_DADDR_LAST  = POS_W'(33);

   typedef enum logic [1:0] {
      VERDICT_DROP = 2'd0,
      VERDICT_PASS = 2'd1,
      VERDICT_CONT = 2'd2
   } verdict_type;

   // register map: register i at byte address 4*i
   localparam int CSR_COUNT  = 2;
   localparam int CSR_ADDR_W = $clog2(CSR_COUNT * 4);

   typedef enum logic [0:0] {
      CSR_RESOLVER = 1'b0,
      CSR_CHAIN    = 1'b1
   } csr_index_type;

   // frame fields as they stand after the current byte
   typedef struct packed {
      pos_type     len;
      logic        decided;
      verdict_type held_verdict;
      logic [3:0]  header_words;
      logic        is_tcp_or_udp;
      logic        later_fragment;
      logic [31:0] dst_addr;
      logic [15:0] l4_dport;
   } frame_info_type;

endpackage

FILE: rtl/dnsf_channels.sv
// dnsf_channels: valid/ready channel interfaces for frame bytes and verdicts
// no dependencies
interface dnsf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_end;

   modport source (output valid, frame_byte, frame_end, input ready);
   modport sink   (input valid, frame_byte, frame_end, output ready);
endinterface

interface dnsf_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] verdict;
   logic [7:0] next_stage;

   modport source (output valid, verdict, next_stage, input ready);
   modport sink   (input valid, verdict, next_stage, output ready);
endinterface

FILE: rtl/dnsf_frame_parser.sv
// dnsf_frame_parser: byte counter and header field capture for one frame at a time
// depends on dnsf_pkg
module dnsf_frame_parser
   import dnsf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           take,
   input  logic [7:0]     frame_byte,
   input  logic           frame_end,
   output frame_info_type info
);

   pos_type     pos_ff, pos_in;
   logic [7:0]  etype_hi_ff, etype_hi_in;
   logic [3:0]  hw_ff, hw_in;
   logic        l4_ok_ff, l4_ok_in;
   logic        frag_ff, frag_in;
   logic [31:0] daddr_ff, daddr_in;
   logic [15:0] dport_ff, dport_in;
   logic        decided_ff, decided_in;
   verdict_type held_ff, held_in;

   logic [7:0]  etype_hi_upd;
   l4_type      l4_start;
   logic        active;

   assign l4_start = L4_W'(ETH_LEN) + L4_W'(hw_ff) * L4_W'(WORD_BYTES);
   assign active   = pos_ff < POS_W'(MAX_FRAME_BYTES);

   always_comb begin
      info         = '{len: pos_ff, decided: decided_ff, held_verdict: held_ff,
                       header_words: hw_ff, is_tcp_or_udp: l4_ok_ff,
                       later_fragment: frag_ff, dst_addr: daddr_ff, l4_dport: dport_ff};
      etype_hi_upd = etype_hi_ff;
      if (take && active) begin
         info.len = pos_ff + POS_W'(1);
         if (!decided_ff) begin
            if (pos_ff == POS_ETYPE_HI) begin
               etype_hi_upd = frame_byte;
            end else if (pos_ff == POS_ETYPE_LO) begin
               if (etype_hi_ff != ETHERTYPE_IPV4[15:8] || frame_byte != ETHERTYPE_IPV4[7:0]) begin
                  info.decided      = 1'b1;
                  info.held_verdict = VERDICT_PASS;
               end
            end else if (pos_ff == POS_IHL) begin
               info.header_words = frame_byte[3:0];
            end else if (pos_ff == POS_FRAG_HI) begin
               info.later_fragment = frame_byte[4:0] != 5'd0;
            end else if (pos_ff == POS_FRAG_LO) begin
               if (frame_byte != 8'd0) begin
                  info.later_fragment = 1'b1;
               end
            end else if (pos_ff == POS_PROTO) begin
               info.is_tcp_or_udp = (frame_byte == PROTO_TCP) || (frame_byte == PROTO_UDP);
            end else if (pos_ff >= POS_DADDR_FIRST && pos_ff <= POS_DADDR_LAST) begin
               info.dst_addr = {daddr_ff[23:0], frame_byte};
            end
            // destination port sits two bytes into the l4 header
            if (hw_ff >= 4'(MIN_IHL) && pos_ff > POS_IHL) begin
               if (pos_ff == POS_W'(l4_start + L4_W'(DPORT_OFS))) begin
                  info.l4_dport = {frame_byte, 8'd0};
               end else if (pos_ff == POS_W'(l4_start + L4_W'(DPORT_OFS + 1))) begin
                  info.l4_dport = {dport_ff[15:8], frame_byte};
               end
            end
         end
      end
   end

   always_comb begin
      pos_in      = info.len;
      etype_hi_in = etype_hi_upd;
      hw_in       = info.header_words;
      l4_ok_in    = info.is_tcp_or_udp;
      frag_in     = info.later_fragment;
      daddr_in    = info.dst_addr;
      dport_in    = info.l4_dport;
      decided_in  = info.decided;
      held_in     = info.held_verdict;
      // every frame starts from a clean slate
      if (take && frame_end) begin
         pos_in      = '0;
         etype_hi_in = '0;
         hw_in       = '0;
         l4_ok_in    = 1'b0;
         frag_in     = 1'b0;
         daddr_in    = '0;
         dport_in    = '0;
         decided_in  = 1'b0;
         held_in     = VERDICT_DROP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         etype_hi_ff <= '0;
         hw_ff       <= '0;
         l4_ok_ff    <= 1'b0;
         frag_ff     <= 1'b0;
         daddr_ff    <= '0;
         dport_ff    <= '0;
         decided_ff  <= 1'b0;
         held_ff     <= VERDICT_DROP;
      end else begin
         pos_ff      <= pos_in;
         etype_hi_ff <= etype_hi_in;
         hw_ff       <= hw_in;
         l4_ok_ff    <= l4_ok_in;
         frag_ff     <= frag_in;
         daddr_ff    <= daddr_in;
         dport_ff    <= dport_in;
         decided_ff  <= decided_in;
         held_ff     <= held_in;
      end
   end

endmodule

FILE: rtl/dns_resolver_packet_filter_top.sv
// dns_resolver_packet_filter_top: per-frame verdict on dns traffic to an approved resolver
// depends on dnsf_pkg, dnsf_channels and dnsf_frame_parser
//
// usage
//   req_chan carries one ethernet frame byte per transaction in wire order, with
//   frame_end high on the last byte of the frame
//   rsp_chan carries one verdict transaction per frame: drop, pass, or continue with
//   next_stage set to the configured chain position (next_stage is zero otherwise)
//   csr port: resolver_address at 0x0, chain_position at 0x4, apb-style, no wait states
// timing
//   one byte is taken every cycle that req ready is high; header fields are captured
//   as they go past and the verdict is formed in the same cycle as the last byte, then
//   held in the output register, so the result appears in the cycle after that byte;
//   one byte per cycle is sustained unless the receiver stalls the single result register
// stall
//   while a verdict waits in the output register and the receiver is not ready,
//   req ready drops for every byte; it rises again in the cycle the verdict is taken,
//   so no verdict is lost or overwritten
// reset
//   synchronous reset clears both registers, the frame state and the output valid bit;
//   the first byte after reset is taken as the start of a frame
module dns_resolver_packet_filter_top
   import dnsf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   dnsf_req_if.sink              req_chan,
   dnsf_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   // configuration registers
   logic [31:0] resolver_ff, resolver_in;
   logic [7:0]  chain_ff, chain_in;
   logic        csr_write;
   csr_index_type csr_sel;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   verdict_type verdict_ff, verdict_in;
   logic [7:0]  next_stage_ff, next_stage_in;

   logic           take;
   logic           load;
   frame_info_type info;
   l4_type         l4_start;
   verdict_type    verdict;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_sel    = csr_index_type'(csr_paddr[2]);

   always_comb begin
      resolver_in = resolver_ff;
      chain_in    = chain_ff;
      if (csr_write) begin
         unique case (csr_sel)
            CSR_RESOLVER: resolver_in = csr_pwdata;
            CSR_CHAIN:    chain_in    = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         CSR_RESOLVER: csr_prdata = resolver_ff;
         CSR_CHAIN:    csr_prdata = {24'd0, chain_ff};
         default:      csr_prdata = '0;
      endcase
   end

   // ---------------- byte intake ----------------
   // a waiting verdict only blocks intake when the receiver stalls it
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign take           = req_chan.valid && req_chan.ready;
   assign load           = take && req_chan.frame_end;

   dnsf_frame_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .frame_byte (req_chan.frame_byte),
      .frame_end  (req_chan.frame_end),
      .info       (info)
   );

   // ---------------- verdict ----------------
   // checks in priority order, on the fields as they stand after the last byte
   assign l4_start = L4_W'(ETH_LEN) + L4_W'(info.header_words) * L4_W'(WORD_BYTES);

   always_comb begin
      if (info.len < POS_W'(ETH_LEN)) begin
         verdict = VERDICT_DROP;
      end else if (info.decided) begin
         verdict = info.held_verdict;
      end else if (info.len < POS_W'(ETH_LEN + IP_HDR_MIN)) begin
         verdict = VERDICT_DROP;
      end else if (info.header_words < 4'(MIN_IHL)) begin
         verdict = VERDICT_DROP;
      end else if (info.len < POS_W'(l4_start)) begin
         verdict = VERDICT_DROP;
      end else if (info.later_fragment) begin
         verdict = VERDICT_DROP;
      end else if (!info.is_tcp_or_udp) begin
         verdict = VERDICT_PASS;
      end else if (info.len < POS_W'(l4_start + L4_W'(L4_PORT_BYTES))) begin
         verdict = VERDICT_DROP;
      end else if (info.l4_dport != RESOLVER_PORT) begin
         verdict = VERDICT_PASS;
      end else if (info.dst_addr != resolver_ff) begin
         verdict = VERDICT_DROP;
      end else begin
         verdict = VERDICT_CONT;
      end
   end

   // ---------------- output register ----------------
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      verdict_in    = verdict_ff;
      next_stage_in = next_stage_ff;
      if (load) begin
         rsp_valid_in  = 1'b1;
         verdict_in    = verdict;
         next_stage_in = (verdict == VERDICT_CONT) ? chain_ff : 8'd0;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         resolver_ff  <= '0;
         chain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         resolver_ff  <= resolver_in;
         chain_ff     <= chain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      verdict_ff    <= verdict_in;
      next_stage_ff <= next_stage_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.verdict    = verdict_ff;
   assign rsp_chan.next_stage = next_stage_ff;

endmodule

FILE: rtl/dnsf_checker.sv
// dnsf_checker: port-level assertions for the dns resolver packet filter, bound to the top
// depends on dnsf_pkg and dns_resolver_packet_filter_top
module dnsf_checker
   import dnsf_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_frame_end,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_verdict,
   input logic [7:0] rsp_next_stage
);

   // a stalled verdict stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_verdict) && $stable(rsp_next_stage))
      else $error("verdict changed while stalled");

   // last byte of a frame gives a verdict in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_frame_end |=> rsp_valid)
      else $error("no verdict after frame end");

   // a mid-frame byte never makes a verdict appear
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_frame_end && !(rsp_valid && !rsp_ready) |=> !rsp_valid)
      else $error("verdict without frame end");

   // next stage is only reported on a continue verdict
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict != VERDICT_CONT |-> rsp_next_stage == 8'd0)
      else $error("next stage set without continue");

   // only defined verdict codes leave the block
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_verdict == VERDICT_DROP || rsp_verdict == VERDICT_PASS ||
                    rsp_verdict == VERDICT_CONT)
      else $error("undefined verdict code");

endmodule

bind dns_resolver_packet_filter_top dnsf_checker u_dnsf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .req_frame_end  (req_chan.frame_end),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_verdict    (rsp_chan.verdict),
   .rsp_next_stage (rsp_chan.next_stage)
);
